/* hdl/ilnf_pkg.sv */
// Package with request and response types and codes for the next-fit allocator.
package ilnf_pkg;

  localparam int CHUNK_W = 17;
  localparam int POS_W   = 40;

  localparam logic [1:0] CMD_INIT  = 2'd0;
  localparam logic [1:0] CMD_ALLOC = 2'd1;
  localparam logic [1:0] CMD_FREE  = 2'd2;

  localparam logic [1:0] ST_DONE      = 2'd0;
  localparam logic [1:0] ST_ZERO      = 2'd1;
  localparam logic [1:0] ST_EXHAUSTED = 2'd2;

  typedef struct packed {
    logic [1:0]  command;
    logic [15:0] request_size;
    logic [15:0] block_address;
  } req_t;

  typedef struct packed {
    logic [15:0] payload_address;
    logic [1:0]  status;
  } rsp_t;

endpackage

/* hdl/ilnf_tag_ram.sv */
// Boundary-tag word memory with one write port and one registered read port.
module ilnf_tag_ram #(
  parameter int DEPTH = 16384,
  parameter int IW    = 14
) (
  input  logic          clk,
  input  logic [IW-1:0] raddr,
  output logic [31:0]   rdata,
  input  logic          we,
  input  logic [IW-1:0] waddr,
  input  logic [31:0]   wdata
);
  logic [31:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

/* hdl/implicit_list_next_fit_allocator_unit.sv */
// Top level of the next-fit heap allocator: command sequencer around the tag memory.
//
//  channel | direction | handshake            | payload
//  req     | in        | req_valid/req_ready  | command, request_size, block_address
//  rsp     | out       | rsp_valid/rsp_ready  | payload_address, status
//  cfg     | in        | cfg_we               | cfg_data (chunk_bytes)
//
// The tag memory has one write port and one registered read port; read data arrives in the cycle after the address.
// Init fails when the chunk does not fit, free may reject the address, allocation walks the blocks
// and may split the one it takes, and a failed search grows the heap.
// Reset is synchronous; the tag memory has no clear and is built by the init command.
// A new request is taken while a finished response still waits in the output register,
// and a later response holds the sequencer until that register is free.
module implicit_list_next_fit_allocator_unit #(
  parameter int HEAP_WORDS = 16384
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              req_valid,
  output logic                              req_ready,
  input  ilnf_pkg::req_t                    req,
  output logic                              rsp_valid,
  input  logic                              rsp_ready,
  output ilnf_pkg::rsp_t                    rsp,
  input  logic                              cfg_we,
  input  logic [ilnf_pkg::CHUNK_W-1:0]      cfg_data
);
  import ilnf_pkg::*;

  localparam int IW = $clog2(HEAP_WORDS);
  localparam int SW = $clog2(HEAP_WORDS) + 1;
  localparam bit IS_POW2 = (HEAP_WORDS & (HEAP_WORDS - 1)) == 0;
  localparam logic [POS_W-1:0] HEAP_BYTES = POS_W'(64'(HEAP_WORDS) * 64'd4);
  localparam logic [POS_W-3:0] HW_W = (POS_W-2)'(HEAP_WORDS);
  localparam logic [SW-1:0] STEP_MAX = SW'(HEAP_WORDS);

  typedef enum logic [4:0] {
    S_IDLE, S_INIT_W, S_GROW_CHK, S_GROW_W,
    S_CO_R0, S_CO_R1, S_CO_R2, S_CO_R3, S_CO_R4, S_CO_R5, S_CO_R6, S_CO_W,
    S_FIT_CHK, S_FIT_D, S_PL_R, S_PL_D, S_PL_W, S_PL_R2, S_PL_D2,
    S_FR_R, S_FR_D, S_FR_W, S_DONE
  } state_t;

  state_t              state;
  logic [1:0]          op;
  logic [1:0]          cnt;
  logic [POS_W-1:0]    bp, p, n, s, psz, nsz, tot, ext, old, brk, rover;
  logic                pa, na, split, rover_valid, heap_ready;
  logic [16:0]         asize;
  logic [SW-1:0]       steps;
  logic [CHUNK_W-1:0]  chunk;
  logic [15:0]         res;
  logic [1:0]          stat;

  logic [31:0]         rdata;
  logic [POS_W-1:0]    rd_pos, wr_pos;
  logic                we;
  logic [31:0]         wr_val;
  logic [POS_W-1:0]    rsz;
  logic [17:0]         chunk_r;
  logic [POS_W-1:0]    fail_ext;
  logic [16:0]         asize_in;

  function automatic logic [IW-1:0] widx(input logic [POS_W-1:0] pos);
    logic [POS_W-3:0] w;
    logic [POS_W-3:0] r;
    w = pos[POS_W-1:2];
    r = (w >= HW_W) ? (w - HW_W) : w;
    return IS_POW2 ? w[IW-1:0] : r[IW-1:0];
  endfunction

  function automatic logic [POS_W-1:0] tsz(input logic [31:0] t);
    return {{(POS_W-32){1'b0}}, t[31:3], 3'b000};
  endfunction

  assign rsz = tsz(rdata);

  always_comb begin
    logic [14:0] cw;
    logic [15:0] cw2;
    cw = chunk[16:2];
    cw2 = {1'b0, cw} + {15'b0, cw[0]};
    chunk_r = (cw2 == 16'd0) ? 18'd8 : {cw2, 2'b00};
    fail_ext = ({1'b0, asize} > chunk_r) ? POS_W'(asize) : POS_W'(chunk_r);
    asize_in = (req.request_size <= 16'd8) ? 17'd16
             : (({1'b0, req.request_size} + 17'd15) & ~17'd7);
  end

  ilnf_tag_ram #(.DEPTH(HEAP_WORDS), .IW(IW)) u_ram (
    .clk(clk), .raddr(widx(rd_pos)), .rdata(rdata),
    .we(we), .waddr(widx(wr_pos)), .wdata(wr_val)
  );

  // Read addresses and write commands for each sequencer step.
  always_comb begin
    rd_pos = '0;
    wr_pos = '0;
    wr_val = '0;
    we = 1'b0;
    unique case (state)
      S_INIT_W: begin
        we = 1'b1;
        wr_pos = POS_W'({cnt, 2'b00});
        wr_val = (cnt == 2'd0) ? 32'd0 : (cnt == 2'd3) ? 32'd1 : 32'd9;
      end
      S_GROW_W: begin
        we = 1'b1;
        case (cnt)
          2'd0: begin wr_pos = bp - 4; wr_val = ext[31:0]; end
          2'd1: begin wr_pos = bp + ext - 8; wr_val = ext[31:0]; end
          default: begin wr_pos = bp + ext - 4; wr_val = 32'd1; end
        endcase
      end
      S_CO_R0: rd_pos = bp - 8;
      S_CO_R1: rd_pos = bp - 4;
      S_CO_R2: rd_pos = p - 4;
      S_CO_R3: rd_pos = p + rsz - 8;
      S_CO_R4: rd_pos = n - 4;
      S_CO_R5: rd_pos = n + rsz - 8;
      S_CO_W: begin
        we = 1'b1;
        wr_val = tot[31:0];
        if (pa) begin
          wr_pos = (cnt == 2'd0) ? bp - 4 : bp + tsz(tot[31:0]) - 8;
        end else if (na) begin
          wr_pos = (cnt == 2'd0) ? bp + s - 8 : p - 4;
        end else begin
          wr_pos = (cnt == 2'd0) ? p - 4 : n + nsz - 8;
        end
      end
      S_FIT_CHK, S_PL_R, S_PL_R2, S_FR_R: rd_pos = bp - 4;
      S_PL_W: begin
        we = 1'b1;
        if (split) begin
          case (cnt)
            2'd0: begin wr_pos = bp - 4; wr_val = {15'b0, asize} | 32'd1; end
            2'd1: begin wr_pos = bp + POS_W'(asize) - 8; wr_val = {15'b0, asize} | 32'd1; end
            2'd2: begin wr_pos = bp + POS_W'(asize) - 4; wr_val = 32'(old - POS_W'(asize)); end
            default: begin wr_pos = bp + old - 8; wr_val = 32'(old - POS_W'(asize)); end
          endcase
        end else begin
          wr_val = old[31:0] | 32'd1;
          wr_pos = (cnt == 2'd0) ? bp - 4 : bp + old - 8;
        end
      end
      S_FR_W: begin
        we = 1'b1;
        wr_val = s[31:0];
        wr_pos = (cnt == 2'd0) ? bp - 4 : bp + s - 8;
      end
      default: ;
    endcase
  end

  assign req_ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      brk <= '0;
      rover <= '0;
      rover_valid <= 1'b0;
      heap_ready <= 1'b0;
      chunk <= CHUNK_W'(4096);
      rsp_valid <= 1'b0;
      cnt <= '0;
    end else begin
      if (cfg_we) begin
        chunk <= cfg_data;
      end
      if (rsp_valid && rsp_ready && state != S_DONE) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (req_valid) begin
            op <= req.command;
            res <= '0;
            stat <= ST_DONE;
            cnt <= '0;
            state <= S_DONE;
            case (req.command)
              CMD_INIT: begin
                brk <= '0;
                rover <= '0;
                rover_valid <= 1'b0;
                state <= S_INIT_W;
              end
              CMD_ALLOC: begin
                if (req.request_size == 16'd0) begin
                  stat <= ST_ZERO;
                end else if (!heap_ready) begin
                  stat <= ST_EXHAUSTED;
                end else begin
                  asize <= asize_in;
                  bp <= rover_valid ? rover : POS_W'(8);
                  steps <= '0;
                  state <= S_FIT_CHK;
                end
              end
              CMD_FREE: begin
                if (heap_ready && req.block_address[2:0] == 3'd0
                    && req.block_address >= 16'd16
                    && POS_W'(req.block_address) < brk) begin
                  bp <= POS_W'(req.block_address);
                  state <= S_FR_R;
                end
              end
              default: ;
            endcase
          end
        end
        S_INIT_W: begin
          cnt <= cnt + 2'd1;
          if (cnt == 2'd3) begin
            brk <= POS_W'(16);
            heap_ready <= 1'b1;
            ext <= POS_W'(chunk_r);
            state <= S_GROW_CHK;
          end
        end
        S_GROW_CHK: begin
          cnt <= '0;
          if (brk + ext > HEAP_BYTES) begin
            stat <= ST_EXHAUSTED;
            state <= S_DONE;
          end else begin
            bp <= brk;
            state <= S_GROW_W;
          end
        end
        S_GROW_W: begin
          cnt <= cnt + 2'd1;
          if (cnt == 2'd2) begin
            brk <= brk + ext;
            state <= S_CO_R0;
          end
        end
        S_CO_R0: state <= S_CO_R1;
        S_CO_R1: begin
          p <= bp - rsz;
          state <= S_CO_R2;
        end
        S_CO_R2: begin
          s <= rsz;
          n <= bp + rsz;
          state <= S_CO_R3;
        end
        S_CO_R3: begin
          psz <= rsz;
          state <= S_CO_R4;
        end
        S_CO_R4: begin
          pa <= rdata[0];
          state <= S_CO_R5;
        end
        S_CO_R5: begin
          na <= rdata[0];
          nsz <= rsz;
          tot <= s + (pa ? rsz : psz);
          cnt <= '0;
          if (pa && rdata[0]) begin
            rover <= bp;
            rover_valid <= 1'b1;
            state <= (op == CMD_ALLOC) ? S_PL_R : S_DONE;
          end else if (!pa && !rdata[0]) begin
            state <= S_CO_R6;
          end else begin
            state <= S_CO_W;
          end
        end
        S_CO_R6: begin
          tot <= tot + rsz;
          state <= S_CO_W;
        end
        S_CO_W: begin
          cnt <= cnt + 2'd1;
          if (cnt == 2'd1) begin
            bp <= pa ? bp : p;
            rover <= pa ? bp : p;
            rover_valid <= 1'b1;
            state <= (op == CMD_ALLOC) ? S_PL_R : S_DONE;
          end
        end
        S_FIT_CHK: begin
          if (steps == STEP_MAX || bp > brk) begin
            ext <= fail_ext;
            state <= S_GROW_CHK;
          end else begin
            state <= S_FIT_D;
          end
        end
        S_FIT_D: begin
          if (rsz == '0) begin
            ext <= fail_ext;
            state <= S_GROW_CHK;
          end else if (!rdata[0] && POS_W'(asize) <= rsz) begin
            state <= S_PL_R;
          end else begin
            bp <= bp + rsz;
            steps <= steps + SW'(1);
            state <= S_FIT_CHK;
          end
        end
        S_PL_R: state <= S_PL_D;
        S_PL_D: begin
          old <= rsz;
          split <= (rsz >= POS_W'(asize)) && (rsz - POS_W'(asize) >= POS_W'(16));
          cnt <= '0;
          state <= S_PL_W;
        end
        S_PL_W: begin
          cnt <= cnt + 2'd1;
          if (cnt == 2'd3 || (!split && cnt == 2'd1)) begin
            state <= S_PL_R2;
          end
        end
        S_PL_R2: state <= S_PL_D2;
        S_PL_D2: begin
          rover <= bp + rsz;
          rover_valid <= 1'b1;
          res <= bp[15:0];
          stat <= ST_DONE;
          state <= S_DONE;
        end
        S_FR_R: state <= S_FR_D;
        S_FR_D: begin
          cnt <= '0;
          if (rdata[0] && rsz != '0 && bp + rsz <= brk) begin
            s <= rsz;
            state <= S_FR_W;
          end else begin
            state <= S_DONE;
          end
        end
        S_FR_W: begin
          cnt <= cnt + 2'd1;
          if (cnt == 2'd1) begin
            state <= S_CO_R0;
          end
        end
        S_DONE: begin
          if (!rsp_valid || rsp_ready) begin
            rsp.payload_address <= (stat == ST_DONE) ? res : 16'd0;
            rsp.status <= stat;
            rsp_valid <= 1'b1;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_addr_zero_on_fail: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (rsp.status == ST_DONE || rsp.payload_address == 16'd0))
    else $error("nonzero address with failing status");
  a_busy_after_req: assert property (@(posedge clk) disable iff (rst)
    (req_valid && req_ready) |=> (state != S_IDLE))
    else $error("sequencer idle right after a request");
  a_heap_ready_sticks: assert property (@(posedge clk) disable iff (rst)
    heap_ready |=> heap_ready)
    else $error("heap_ready dropped");
  a_break_aligned: assert property (@(posedge clk) disable iff (rst)
    brk[2:0] == 3'd0)
    else $error("break offset not a multiple of eight");
  a_break_bound: assert property (@(posedge clk) disable iff (rst)
    brk <= HEAP_BYTES)
    else $error("break offset beyond heap bound");
`endif
endmodule

/* test/tb.sv */
// Testbench for the next-fit heap allocator: predicts every response and checks it.
`timescale 1ns / 1ps

module tb;
  import ilnf_pkg::*;

  localparam int WORDS = 16384;
  localparam longint unsigned HEAP_LIMIT = 64'd65536;

  logic clk;
  logic rst;
  logic req_valid;
  logic req_ready;
  req_t req;
  logic rsp_valid;
  logic rsp_ready;
  rsp_t rsp;
  logic cfg_we;
  logic [CHUNK_W-1:0] cfg_data;

  implicit_list_next_fit_allocator_unit u_top (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_ready(req_ready), .req(req),
    .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp),
    .cfg_we(cfg_we), .cfg_data(cfg_data)
  );

  // Predictor state of the heap.
  logic [31:0] tags [0:WORDS-1];
  longint unsigned brk;
  longint unsigned rover;
  bit rover_ok;
  bit heap_up;
  logic [CHUNK_W-1:0] chunk;

  rsp_t expected_rsp[$];
  logic [15:0] live_blocks[$];
  int errors;
  int send_idle_pct;
  int recv_stall_pct;
  int hold_cycles;

  function automatic logic [31:0] tag_rd(longint unsigned pos);
    return tags[(pos >> 2) % WORDS];
  endfunction

  function automatic void tag_wr(longint unsigned pos, longint unsigned v);
    tags[(pos >> 2) % WORDS] = v[31:0];
  endfunction

  function automatic longint unsigned blk_len(longint unsigned bp);
    return longint'(tag_rd(bp - 4) & 32'hFFFF_FFF8);
  endfunction

  function automatic longint unsigned merge_free(longint unsigned bp);
    longint unsigned p, n, sz, f;
    bit pa, na;
    p = bp - longint'(tag_rd(bp - 8) & 32'hFFFF_FFF8);
    n = bp + blk_len(bp);
    pa = (tag_rd(p + blk_len(p) - 8) & 32'd1) != 32'd0;
    na = (tag_rd(n - 4) & 32'd1) != 32'd0;
    sz = blk_len(bp);
    if (pa && !na) begin
      sz += blk_len(n);
      tag_wr(bp - 4, sz);
      tag_wr(bp + blk_len(bp) - 8, sz);
    end else if (!pa && na) begin
      f = bp + blk_len(bp) - 8;
      sz += blk_len(p);
      tag_wr(f, sz);
      tag_wr(p - 4, sz);
      bp = p;
    end else if (!pa && !na) begin
      f = n + blk_len(n) - 8;
      sz += blk_len(p) + longint'(tag_rd(f) & 32'hFFFF_FFF8);
      tag_wr(p - 4, sz);
      tag_wr(f, sz);
      bp = p;
    end
    rover = bp;
    rover_ok = 1;
    return bp;
  endfunction

  function automatic bit heap_grow(longint unsigned bytes, output longint unsigned bp_out);
    longint unsigned bp;
    bp = brk;
    bp_out = 0;
    if (bp + bytes > HEAP_LIMIT) return 0;
    tag_wr(bp - 4, bytes);
    tag_wr(bp + bytes - 8, bytes);
    tag_wr(bp + bytes - 4, 1);
    brk = bp + bytes;
    bp_out = merge_free(bp);
    return 1;
  endfunction

  function automatic longint unsigned chunk_len();
    longint unsigned w;
    w = longint'(chunk) >> 2;
    if (w & 1) w++;
    return (w != 0) ? w * 4 : 8;
  endfunction

  function automatic void carve(longint unsigned bp, longint unsigned asize);
    longint unsigned old, n;
    old = blk_len(bp);
    if (old >= asize && old - asize >= 16) begin
      tag_wr(bp - 4, asize | 1);
      tag_wr(bp + blk_len(bp) - 8, asize | 1);
      n = bp + asize;
      tag_wr(n - 4, old - asize);
      tag_wr(n + blk_len(n) - 8, old - asize);
    end else begin
      tag_wr(bp - 4, old | 1);
      tag_wr(bp + blk_len(bp) - 8, old | 1);
    end
    rover = bp + blk_len(bp);
  endfunction

  function automatic bit search_fit(longint unsigned asize, output longint unsigned bp_out);
    longint unsigned bp, sz;
    bp = rover_ok ? rover : 8;
    bp_out = 0;
    for (int s = 0; s < WORDS; s++) begin
      if (bp > brk) return 0;
      sz = blk_len(bp);
      if (sz == 0) return 0;
      if (!(tag_rd(bp - 4) & 1) && asize <= sz) begin
        bp_out = bp;
        return 1;
      end
      bp += sz;
    end
    return 0;
  endfunction

  // Applies one request to the predicted heap and returns the response it must produce.
  function automatic rsp_t predict_heap_op(req_t r);
    rsp_t o;
    longint unsigned bp, asize, ext, sz, a;
    logic [31:0] h;
    o = '0;
    a = 64'(r.block_address);
    if (r.command == CMD_INIT) begin
      brk = 0;
      rover_ok = 0;
      rover = 0;
      tag_wr(0, 0);
      tag_wr(4, 9);
      tag_wr(8, 9);
      tag_wr(12, 1);
      brk = 16;
      heap_up = 1;
      live_blocks.delete();
      if (!heap_grow(chunk_len(), bp)) o.status = ST_EXHAUSTED;
    end else if (r.command == CMD_ALLOC) begin
      if (r.request_size == 0) begin
        o.status = ST_ZERO;
      end else if (!heap_up) begin
        o.status = ST_EXHAUSTED;
      end else begin
        asize = (r.request_size <= 8) ? 16 : 8 * ((longint'(r.request_size) + 15) / 8);
        if (search_fit(asize, bp)) begin
          carve(bp, asize);
          o.payload_address = bp[15:0];
        end else begin
          ext = chunk_len();
          if (asize > ext) ext = asize;
          if (heap_grow(ext, bp)) begin
            carve(bp, asize);
            o.payload_address = bp[15:0];
          end else begin
            o.status = ST_EXHAUSTED;
          end
        end
        if (o.status == ST_DONE) live_blocks.push_back(o.payload_address);
      end
    end else if (r.command == CMD_FREE) begin
      if (heap_up && (a & 7) == 0 && a >= 16 && a < brk) begin
        h = tag_rd(a - 4);
        sz = longint'(h & 32'hFFFF_FFF8);
        if (h[0] && sz != 0 && a + sz <= brk) begin
          tag_wr(a - 4, sz);
          tag_wr(a + blk_len(a) - 8, sz);
          void'(merge_free(a));
        end
      end
      foreach (live_blocks[i]) begin
        if (live_blocks[i] == r.block_address) begin
          live_blocks.delete(i);
          break;
        end
      end
    end
    return o;
  endfunction

  task automatic report_mismatch(string what, logic [17:0] got, logic [17:0] want);
    $display("MISMATCH %s: got 0x%0h, expected 0x%0h at %0t", what, got, want, $realtime);
    errors++;
  endtask

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    #400ms;
    $display("implicit_list_next_fit_allocator_unit verification failed");
    $finish;
  end

  // Receiver: random stalls, plus long hold-offs when requested.
  initial begin
    rsp_ready = 0;
    forever begin
      @(negedge clk);
      if (hold_cycles > 0) begin
        rsp_ready <= 0;
        hold_cycles--;
      end else begin
        rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // Response checker.
  initial begin
    rsp_t want;
    forever begin
      @(posedge clk);
      if (!rst && rsp_valid && rsp_ready) begin
        if (expected_rsp.size() == 0) begin
          report_mismatch("unexpected response", rsp, 18'd0);
        end else begin
          want = expected_rsp.pop_front();
          if (rsp.payload_address !== want.payload_address)
            report_mismatch("payload_address", {2'b00, rsp.payload_address},
                            {2'b00, want.payload_address});
          if (rsp.status !== want.status)
            report_mismatch("status", {16'd0, rsp.status}, {16'd0, want.status});
        end
      end
    end
  end

  // Offers one request, called at a falling edge; valid stays high for the next call.
  task automatic send_request(logic [1:0] cmd, logic [15:0] sz, logic [15:0] addr);
    req_t r;
    r.command = cmd;
    r.request_size = sz;
    r.block_address = addr;
    if ($urandom_range(99) < send_idle_pct) begin
      req_valid <= 0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    req_valid <= 1;
    req <= r;
    do @(posedge clk); while (!req_ready);
    expected_rsp.push_back(predict_heap_op(r));
    @(negedge clk);
  endtask

  task automatic wait_idle();
    req_valid <= 0;
    while (expected_rsp.size() != 0) @(negedge clk);
    repeat (64) @(negedge clk);
  endtask

  task automatic set_chunk(logic [CHUNK_W-1:0] v);
    wait_idle();
    cfg_we <= 1;
    cfg_data <= v;
    chunk = v;
    @(negedge clk);
    cfg_we <= 0;
  endtask

  task automatic free_random_live();
    int k;
    if (live_blocks.size() == 0) begin
      send_request(CMD_ALLOC, 16'($urandom_range(1, 64)), 16'($urandom));
    end else begin
      k = $urandom_range(live_blocks.size() - 1);
      send_request(CMD_FREE, 16'($urandom), live_blocks[k]);
    end
  endtask

  task automatic test_before_init();
    send_request(CMD_ALLOC, 16'd1, 16'd0);
    send_request(CMD_FREE, 16'd0, 16'd16);
    send_request(CMD_ALLOC, 16'd0, 16'hFFFF);
    send_request(2'd3, 16'hFFFF, 16'hFFFF);
  endtask

  task automatic test_directed_ops();
    logic [15:0] a;
    send_request(CMD_INIT, 16'hFFFF, 16'hFFFF);
    send_request(CMD_ALLOC, 16'd1, 16'd0);
    send_request(CMD_ALLOC, 16'd8, 16'd0);
    send_request(CMD_ALLOC, 16'd9, 16'd0);
    send_request(CMD_ALLOC, 16'd0, 16'd0);
    send_request(CMD_ALLOC, 16'hFFFF, 16'd0);
    send_request(CMD_ALLOC, 16'd5000, 16'd0);
    a = live_blocks[1];
    send_request(CMD_FREE, 16'd0, a);
    send_request(CMD_FREE, 16'd0, a);
    send_request(CMD_FREE, 16'd0, live_blocks[0]);
    send_request(CMD_FREE, 16'd0, 16'd20);
    send_request(CMD_FREE, 16'd0, 16'd8);
    send_request(CMD_FREE, 16'd0, 16'hFFF8);
    send_request(2'd3, 16'd0, 16'd0);
    send_request(CMD_ALLOC, 16'd100, 16'd0);
    send_request(CMD_INIT, 16'd0, 16'd0);
    send_request(CMD_ALLOC, 16'd60000, 16'd0);
    send_request(CMD_ALLOC, 16'd60000, 16'd0);
  endtask

  task automatic test_chunk_extremes();
    set_chunk(17'd8);
    send_request(CMD_INIT, 16'd0, 16'd0);
    send_request(CMD_ALLOC, 16'd24, 16'd0);
    send_request(CMD_ALLOC, 16'd1, 16'd0);
    send_request(CMD_FREE, 16'd0, live_blocks[0]);
    set_chunk(17'd65536);
    send_request(CMD_INIT, 16'd0, 16'd0);
    send_request(CMD_ALLOC, 16'd4, 16'd0);
    set_chunk(17'h1FFFF);
    send_request(CMD_INIT, 16'd0, 16'd0);
    send_request(CMD_ALLOC, 16'd4, 16'd0);
    set_chunk(17'd65535);
    send_request(CMD_INIT, 16'd0, 16'd0);
    send_request(CMD_ALLOC, 16'd4, 16'd0);
  endtask

  // Mostly allocs and live frees; also bad frees, zero sizes, bad commands, re-inits.
  task automatic random_traffic(int n);
    int pick;
    logic [15:0] sz;
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(99);
      if (pick < 47) begin
        case ($urandom_range(9))
          0: sz = 16'($urandom);
          1, 2: sz = 16'($urandom_range(1, 4096));
          default: sz = 16'($urandom_range(1, 256));
        endcase
        send_request(CMD_ALLOC, sz, 16'($urandom));
      end else if (pick < 88) begin
        free_random_live();
      end else if (pick < 91) begin
        send_request(CMD_FREE, 16'($urandom), 16'($urandom) | 16'd1);
      end else if (pick < 93) begin
        send_request(CMD_FREE, 16'($urandom), 16'hFFF8 - 16'($urandom_range(3) * 8));
      end else if (pick < 95) begin
        send_request(CMD_ALLOC, 16'd0, 16'($urandom));
      end else if (pick < 96) begin
        send_request(2'd3, 16'($urandom), 16'($urandom));
      end else if (pick < 98 && live_blocks.size() < 8) begin
        send_request(CMD_INIT, 16'($urandom), 16'($urandom));
      end else begin
        send_request(CMD_ALLOC, 16'($urandom_range(1, 32)), 16'($urandom));
      end
    end
  endtask

  task automatic test_random_phases();
    set_chunk(17'd4096);
    send_request(CMD_INIT, 16'd0, 16'd0);
    send_idle_pct = 0;  recv_stall_pct = 0;  random_traffic(220);
    send_idle_pct = 53; recv_stall_pct = 0;  random_traffic(200);
    set_chunk(17'($urandom_range(8, 2048)));
    send_request(CMD_INIT, 16'd0, 16'd0);
    send_idle_pct = 0;  recv_stall_pct = 53; random_traffic(200);
    set_chunk(17'd1024);
    send_request(CMD_INIT, 16'd0, 16'd0);
    send_idle_pct = 26; recv_stall_pct = 26; random_traffic(230);
  endtask

  task automatic test_output_backpressure();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_cycles = 400;
    random_traffic(30);
  endtask

  initial begin
    errors = 0;
    hold_cycles = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    heap_up = 0;
    rover_ok = 0;
    rover = 0;
    brk = 0;
    chunk = 17'd4096;
    rst = 1;
    req_valid = 0;
    req = '0;
    cfg_we = 0;
    cfg_data = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 0;
    @(negedge clk);
    test_before_init();
    test_directed_ops();
    test_chunk_extremes();
    test_random_phases();
    test_output_backpressure();
    req_valid <= 0;
    while (expected_rsp.size() != 0) @(negedge clk);
    repeat (100) @(negedge clk);
    if (errors == 0) begin
      $display("implicit_list_next_fit_allocator_unit verification clean");
    end else begin
      $display("implicit_list_next_fit_allocator_unit verification failed");
    end
    $finish;
  end

endmodule
